@@ hdl/twelve_hour_clock_digits_seg7_macros.svh @@
// Assertion macros shared by the clock digit keeper.
`ifndef TWELVE_HOUR_CLOCK_DIGITS_SEG7_MACROS_SVH
`define TWELVE_HOUR_CLOCK_DIGITS_SEG7_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define THCD_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define THCD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ hdl/thcd_pkg.sv @@
`default_nettype none

package thcd_pkg;

    // Opcodes
    localparam logic [1:0] OP_ADVANCE = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_SYNC    = 2'd2;

    // Digit positions
    localparam logic [1:0] POS_MIN_ONES = 2'd0;
    localparam logic [1:0] POS_MIN_TENS = 2'd1;
    localparam logic [1:0] POS_AMPM     = 2'd2;
    localparam logic [1:0] POS_HOUR     = 2'd3;

    // Fixed segment codes, common anode, bit 7 is segment a
    localparam logic [7:0] SEG_PM    = 8'h31;
    localparam logic [7:0] SEG_AM    = 8'h11;
    localparam logic [7:0] SEG_BLANK = 8'hff;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] digit_position;
        logic [3:0] load_hour;
        logic       load_pm;
        logic [3:0] load_minute_tens;
        logic [3:0] load_minute_ones;
        logic [3:0] sampled_ones_digit;
        logic [2:0] blank_position;
    } thcd_in_t;

    typedef struct packed {
        logic [7:0] segments_minute_ones;
        logic [7:0] segments_minute_tens;
        logic [7:0] segments_sign;
        logic [7:0] segments_hour;
        logic [4:0] hour_bcd;
        logic       pm_now;
        logic       load_error;
    } thcd_out_t;

    typedef struct packed {
        logic [3:0] hour;
        logic       pm;
        logic [2:0] min_tens;
        logic [3:0] min_ones;
    } thcd_time_t;

    localparam thcd_time_t TIME_RESET = '{hour: 4'd3, pm: 1'b0, min_tens: 3'd1,
                                          min_ones: 4'd5};

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h03;
            4'd1:    code = 8'h9f;
            4'd2:    code = 8'h25;
            4'd3:    code = 8'h0d;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h49;
            4'd6:    code = 8'h41;
            4'd7:    code = 8'h1f;
            4'd8:    code = 8'h01;
            4'd9:    code = 8'h09;
            4'd10:   code = 8'h11;
            4'd11:   code = 8'hc1;
            4'd12:   code = 8'h63;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hdl/thcd_time.sv @@
`default_nettype none

module thcd_time
    import thcd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire thcd_in_t   cmd,
    output      thcd_time_t time_now,
    output      thcd_time_t time_next,
    output      logic       load_error
);

    thcd_time_t time_reg;
    logic       do_ones;
    logic       do_tens;
    logic       do_hour;
    logic       flip_pm;
    logic       tens_inc;
    logic       hour_inc;
    logic       load_ok;

    always_comb
    begin
        do_ones = 1'b0;
        do_tens = 1'b0;
        do_hour = 1'b0;
        flip_pm = 1'b0;
        if (cmd.opcode == OP_ADVANCE)
        begin
            unique case (cmd.digit_position)
                POS_MIN_ONES: do_ones = 1'b1;
                POS_MIN_TENS: do_tens = 1'b1;
                POS_AMPM:     flip_pm = 1'b1;
                POS_HOUR:     do_hour = 1'b1;
                default:      do_ones = 1'b0;
            endcase
        end
        else if (cmd.opcode == OP_SYNC)
        begin
            do_ones = (cmd.sampled_ones_digit != time_reg.min_ones);
        end
    end

    // Carry chain: ones -> tens -> hour
    assign tens_inc = do_tens | (do_ones & (time_reg.min_ones >= 4'd9));
    assign hour_inc = do_hour | (tens_inc & (time_reg.min_tens >= 3'd5));

    assign load_error = (cmd.opcode == OP_LOAD) &&
                        ((cmd.load_hour == 4'd0) || (cmd.load_hour > 4'd12) ||
                         (cmd.load_minute_tens > 4'd5) || (cmd.load_minute_ones > 4'd9));
    assign load_ok    = (cmd.opcode == OP_LOAD) && !load_error;

    always_comb
    begin
        time_next = time_reg;
        if (load_ok)
        begin
            time_next.hour     = cmd.load_hour;
            time_next.pm       = cmd.load_pm;
            time_next.min_tens = cmd.load_minute_tens[2:0];
            time_next.min_ones = cmd.load_minute_ones;
        end
        else
        begin
            if (do_ones)
                time_next.min_ones = (time_reg.min_ones >= 4'd9) ? 4'd0
                                     : time_reg.min_ones + 4'd1;
            if (tens_inc)
                time_next.min_tens = (time_reg.min_tens >= 3'd5) ? 3'd0
                                     : time_reg.min_tens + 3'd1;
            if (hour_inc)
                time_next.hour = (time_reg.hour >= 4'd12) ? 4'd1
                                 : time_reg.hour + 4'd1;
            // Flip am/pm on 11 -> 12, or on a direct am/pm advance
            time_next.pm = time_reg.pm ^ flip_pm ^ (hour_inc && (time_reg.hour == 4'd11));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            time_reg <= TIME_RESET;
        else if (fire)
            time_reg <= time_next;
    end

    assign time_now = time_reg;

endmodule

`default_nettype wire

@@ hdl/thcd_display.sv @@
`default_nettype none

module thcd_display
    import thcd_pkg::*;
(
    input  wire thcd_time_t tm,
    input  wire logic [2:0] blank_position,
    input  wire logic       load_error,
    output      thcd_out_t  result
);

    logic [7:0] codes [4];

    always_comb
    begin
        codes[0] = seg_code(tm.min_ones);
        codes[1] = seg_code({1'b0, tm.min_tens});
        codes[2] = tm.pm ? SEG_PM : SEG_AM;
        codes[3] = seg_code(tm.hour);
        for (int i = 0; i < 4; i++)
        begin
            if (blank_position == 3'(i))
                codes[i] = SEG_BLANK;
        end
    end

    assign result.segments_minute_ones = codes[0];
    assign result.segments_minute_tens = codes[1];
    assign result.segments_sign        = codes[2];
    assign result.segments_hour        = codes[3];
    assign result.hour_bcd = (tm.hour > 4'd9) ? {1'b1, 4'(tm.hour - 4'd10)}
                                              : {1'b0, tm.hour};
    assign result.pm_now     = tm.pm;
    assign result.load_error = load_error;

endmodule

`default_nettype wire

@@ hdl/twelve_hour_clock_digits_seg7.sv @@
// Twelve-hour clock digit keeper with seven-segment output. Each transfer on
// the item channel carries one command (advance a digit, load a whole time, or
// sync against a sampled RTC minute digit) and yields exactly one transfer on
// the result channel with four common-anode segment codes, the hour in BCD, the
// am/pm flag, all taken from the time after the command, and a load error flag.
// Commands take effect in arrival order. Each item is held in the input
// register, updates the time registers as it leaves, and its result is
// captured in the result register, which holds it while result_stall is high.
// Throughput is one item per cycle while the result channel does not stall. A
// stalled result does not block the input register, so one more item is taken
// while the result waits. Reset time is 3:15 am.
`default_nettype none

`include "twelve_hour_clock_digits_seg7_macros.svh"

module twelve_hour_clock_digits_seg7
    import thcd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      item_valid,
    output      logic      item_stall,
    input  wire thcd_in_t  item,
    output      logic      result_valid,
    input  wire logic      result_stall,
    output      thcd_out_t result
);

    // Input register
    logic       in_valid_reg;
    logic       in_valid_next;
    thcd_in_t   in_data_reg;

    // Result register
    logic       out_valid_reg;
    logic       out_valid_next;
    thcd_out_t  out_data_reg;

    logic       out_free;
    logic       fire;
    logic       err;
    thcd_time_t time_now;
    thcd_time_t time_next;
    thcd_out_t  encoded;

    // Result register takes a new value when empty or draining this cycle
    assign out_free = !out_valid_reg || !result_stall;
    // Execute: the held item updates the time and moves to the result register
    assign fire = in_valid_reg && out_free;
    // Hold the input only while its item cannot move on
    assign item_stall = in_valid_reg && !out_free;

    assign in_valid_next  = (item_valid && !item_stall) || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture a new item on each input transfer
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_data_reg <= item;
    end

    // Time state and its next-value logic
    thcd_time u_time (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .cmd        (in_data_reg),
        .time_now   (time_now),
        .time_next  (time_next),
        .load_error (err)
    );

    // Segment and BCD encode from the updated time
    thcd_display u_display (
        .tm             (time_next),
        .blank_position (in_data_reg.blank_position),
        .load_error     (err),
        .result         (encoded)
    );

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= encoded;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `THCD_ASSERT_NOW(a_time_legal, 1'b1,
        (time_now.hour >= 4'd1) && (time_now.hour <= 4'd12) &&
        (time_now.min_tens <= 3'd5) && (time_now.min_ones <= 4'd9),
        "time registers left the legal range")
    `THCD_ASSERT_NEXT(a_bad_load_holds, fire && err,
        time_now == $past(time_now), "rejected load changed the time")
    `THCD_ASSERT_NEXT(a_result_matches_time, fire,
        (result.pm_now == time_now.pm) && out_valid_reg,
        "result does not reflect the updated time")
    `THCD_ASSERT_NOW(a_stall_needs_item, item_stall,
        in_valid_reg && out_valid_reg, "input stalled with room downstream")

endmodule

`default_nettype wire
